// ----- hdl/trie_root_word_replacer_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the trie root word replacer
// Clocked on clock, quiet while reset is high.
// ---------------------------------------------------------------------------
`ifndef TRIE_ROOT_WORD_REPLACER_UNIT_MACROS_SVH
`define TRIE_ROOT_WORD_REPLACER_UNIT_MACROS_SVH

`define TRWR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define TRWR_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- hdl/trwr_pkg.sv -----
// ---------------------------------------------------------------------------
// trwr_pkg
// Types and constants shared by the trie root word replacer.
// ---------------------------------------------------------------------------
package trwr_pkg;

   localparam int NODES    = 1024;
   localparam int ALPHABET = 26;
   localparam int NODE_W   = $clog2(NODES);
   localparam int USED_W   = $clog2(NODES + 1);
   localparam int SLOTS    = NODES * ALPHABET;
   localparam int ADDR_W   = $clog2(SLOTS);
   localparam int IDX_W    = $clog2(ALPHABET);

   localparam logic [7:0] CHAR_A       = 8'd97;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic       CMD_DICT     = 1'b0;
   localparam logic       CMD_SENTENCE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_GAP    = 2'd0,
      MODE_FOLLOW = 2'd1,
      MODE_COPY   = 2'd2,
      MODE_ROOT   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_CLEAR = 2'd0,
      PH_FETCH = 2'd1,
      PH_EXEC  = 2'd2
   } phase_type;

   typedef struct packed {
      logic       command;
      logic [7:0] char_code;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       sentence_end;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic             command;
      logic [7:0]       char_code;
      logic             end_mark;
      logic             is_letter;
      logic             is_space;
      logic [IDX_W-1:0] idx;
   } item_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic              mark;
      logic [NODE_W-1:0] child;
   } link_type;

endpackage

// ----- hdl/trwr_front.sv -----
// ---------------------------------------------------------------------------
// trwr_front
// Accepts requests, classifies the byte and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module trwr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear_done,
   input  logic               req_valid,
   output logic               req_ready,
   input  trwr_pkg::req_type  req_payload,
   output logic               head_valid,
   output trwr_pkg::item_type head,
   input  logic               pop
);

   trwr_pkg::item_type entry_ff [2];
   trwr_pkg::item_type item_in;
   logic [1:0]         count_ff, count_in;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic               push;
   logic [7:0]         offset;

   assign req_ready  = clear_done && (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      offset              = req_payload.char_code - trwr_pkg::CHAR_A;
      item_in.command     = req_payload.command;
      item_in.char_code   = req_payload.char_code;
      item_in.end_mark    = req_payload.end_mark;
      item_in.is_letter   = (req_payload.char_code >= trwr_pkg::CHAR_A) &&
                            (offset < 8'(trwr_pkg::ALPHABET));
      item_in.is_space    = (req_payload.char_code == trwr_pkg::CHAR_SPACE);
      item_in.idx         = offset[trwr_pkg::IDX_W-1:0];
      wr_ptr_in           = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in           = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in            = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ----- hdl/trwr_outq.sv -----
// ---------------------------------------------------------------------------
// trwr_outq
// Four-entry result queue; takes up to two results a cycle, gives one.
// ---------------------------------------------------------------------------
module trwr_outq (
   input  logic               clock,
   input  logic               reset,
   input  trwr_pkg::push_type push,
   output logic               space_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output trwr_pkg::rsp_type  rsp_payload
);

   trwr_pkg::rsp_type entry_ff [4];
   logic [2:0]        count_ff, count_in;
   logic [1:0]        wr_ptr_ff, wr_ptr_in;
   logic [1:0]        rd_ptr_ff, rd_ptr_in;
   logic              pop;

   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign space_ok    = (count_ff <= 3'd2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 3'd0;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

endmodule

// ----- hdl/trwr_back.sv -----
// ---------------------------------------------------------------------------
// trwr_back
// Trie engine: clears the link memory, then reads one link per item and
// inserts dictionary bytes or filters sentence bytes.
// ---------------------------------------------------------------------------
`include "trie_root_word_replacer_unit_macros.svh"

module trwr_back (
   input  logic               clock,
   input  logic               reset,
   output logic               clear_done,
   input  logic               head_valid,
   input  trwr_pkg::item_type head,
   output logic               pop,
   input  logic               space_ok,
   output trwr_pkg::push_type push
);

   localparam int NW = trwr_pkg::NODE_W;
   localparam int AW = trwr_pkg::ADDR_W;
   localparam int UW = trwr_pkg::USED_W;

   trwr_pkg::link_type link_mem [trwr_pkg::SLOTS];
   trwr_pkg::link_type rdata_ff;

   trwr_pkg::phase_type phase_ff, phase_in;
   logic [AW-1:0]       clear_ff, clear_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [UW-1:0]       used_ff, used_in;
   logic [NW-1:0]       icur_ff, icur_in;
   logic [AW-1:0]       islot_ff, islot_in;
   logic                broken_ff, broken_in;
   logic [NW-1:0]       mcur_ff, mcur_in;
   trwr_pkg::mode_type  mode_ff, mode_in;
   logic                pend_ff, pend_in;
   logic                sent_ff, sent_in;

   logic                rd_en;
   logic [NW-1:0]       rd_cur;
   logic                we;
   logic [AW-1:0]       wa;
   trwr_pkg::link_type  wd;
   logic [NW-1:0]       child;
   logic                new_node;
   trwr_pkg::rsp_type   res [2];
   logic [1:0]          n;

   assign clear_done = (phase_ff != trwr_pkg::PH_CLEAR);

   always_comb begin
      phase_in  = phase_ff;
      clear_in  = clear_ff;
      addr_in   = addr_ff;
      used_in   = used_ff;
      icur_in   = icur_ff;
      islot_in  = islot_ff;
      broken_in = broken_ff;
      mcur_in   = mcur_ff;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      sent_in   = sent_ff;
      rd_en     = 1'b0;
      rd_cur    = '0;
      we        = 1'b0;
      wa        = addr_ff;
      wd        = '0;
      child     = rdata_ff.child;
      new_node  = 1'b0;
      pop       = 1'b0;
      n         = 2'd0;
      res[0]    = '{8'd0, 1'b0, 1'b0, trwr_pkg::ST_OK};
      res[1]    = '{8'd0, 1'b0, 1'b0, trwr_pkg::ST_OK};

      case (phase_ff)
         trwr_pkg::PH_CLEAR: begin
            we       = 1'b1;
            wa       = clear_ff;
            clear_in = clear_ff + 1'b1;
            if (clear_ff == AW'(trwr_pkg::SLOTS - 1)) begin
               phase_in = trwr_pkg::PH_FETCH;
            end
         end
         trwr_pkg::PH_FETCH: begin
            if (head.command == trwr_pkg::CMD_DICT) begin
               rd_cur = icur_ff;
            end else if (mode_ff != trwr_pkg::MODE_GAP) begin
               rd_cur = mcur_ff;
            end
            addr_in = AW'(rd_cur * trwr_pkg::ALPHABET) + AW'(head.idx);
            if (head_valid && space_ok) begin
               rd_en    = 1'b1;
               phase_in = trwr_pkg::PH_EXEC;
            end
         end
         trwr_pkg::PH_EXEC: begin
            pop      = 1'b1;
            phase_in = trwr_pkg::PH_FETCH;
            if (head.command == trwr_pkg::CMD_DICT) begin
               if (!head.is_letter) begin
                  res[0].status = trwr_pkg::ST_BAD;
                  n             = 2'd1;
               end else if (broken_ff) begin
                  res[0].status = trwr_pkg::ST_FULL;
                  n             = 2'd1;
               end else begin
                  if (rdata_ff.child == '0) begin
                     if (used_ff >= UW'(trwr_pkg::NODES)) begin
                        broken_in     = 1'b1;
                        res[0].status = trwr_pkg::ST_FULL;
                        n             = 2'd1;
                     end else begin
                        child    = used_ff[NW-1:0];
                        used_in  = used_ff + 1'b1;
                        new_node = 1'b1;
                     end
                  end
                  if (!broken_in) begin
                     icur_in  = child;
                     islot_in = addr_ff;
                  end
                  if (new_node) begin
                     we = 1'b1;
                     wa = addr_ff;
                     wd = '{head.end_mark, child};
                  end
               end
               if (head.end_mark) begin
                  if (!broken_in && (icur_in != '0)) begin
                     we = 1'b1;
                     wa = islot_in;
                     wd = '{1'b1, icur_in};
                  end
                  icur_in   = '0;
                  broken_in = 1'b0;
               end
            end else begin
               if (head.is_space) begin
                  if (mode_ff != trwr_pkg::MODE_GAP) begin
                     mode_in = trwr_pkg::MODE_GAP;
                     mcur_in = '0;
                     pend_in = 1'b1;
                  end
               end else if (!head.is_letter) begin
                  res[0].status = trwr_pkg::ST_BAD;
                  n             = 2'd1;
               end else begin
                  if (mode_ff == trwr_pkg::MODE_GAP) begin
                     if (pend_ff && sent_ff) begin
                        res[0] = '{trwr_pkg::CHAR_SPACE, 1'b1, 1'b0, trwr_pkg::ST_OK};
                        n      = 2'd1;
                     end
                     pend_in = 1'b0;
                     sent_in = 1'b1;
                     mode_in = trwr_pkg::MODE_FOLLOW;
                     mcur_in = '0;
                  end
                  if (mode_in == trwr_pkg::MODE_FOLLOW) begin
                     if (rdata_ff.child == '0) begin
                        mode_in = trwr_pkg::MODE_COPY;
                     end else begin
                        mcur_in = rdata_ff.child;
                        if (rdata_ff.mark) begin
                           mode_in = trwr_pkg::MODE_ROOT;
                        end
                     end
                     res[n[0]] = '{head.char_code, 1'b1, 1'b0, trwr_pkg::ST_OK};
                     n         = n + 2'd1;
                  end else if (mode_in == trwr_pkg::MODE_COPY) begin
                     res[n[0]] = '{head.char_code, 1'b1, 1'b0, trwr_pkg::ST_OK};
                     n         = n + 2'd1;
                  end
               end
               if (head.end_mark) begin
                  if (n == 2'd0) begin
                     res[0].sentence_end = 1'b1;
                     n                   = 2'd1;
                  end else begin
                     res[n[1]].sentence_end = 1'b1;
                  end
                  mode_in = trwr_pkg::MODE_GAP;
                  mcur_in = '0;
                  pend_in = 1'b0;
                  sent_in = 1'b0;
               end
            end
         end
         default: begin
            phase_in = trwr_pkg::PH_CLEAR;
         end
      endcase

      push.count  = n;
      push.first  = res[0];
      push.second = res[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= trwr_pkg::PH_CLEAR;
         clear_ff  <= '0;
         used_ff   <= UW'(1);
         icur_ff   <= '0;
         islot_ff  <= '0;
         broken_ff <= 1'b0;
         mcur_ff   <= '0;
         mode_ff   <= trwr_pkg::MODE_GAP;
         pend_ff   <= 1'b0;
         sent_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         clear_ff  <= clear_in;
         used_ff   <= used_in;
         icur_ff   <= icur_in;
         islot_ff  <= islot_in;
         broken_ff <= broken_in;
         mcur_ff   <= mcur_in;
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         sent_ff   <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         link_mem[wa] <= wd;
      end
      if (rd_en) begin
         rdata_ff <= link_mem[addr_in];
      end
   end

   `TRWR_ASSERT(a_used_bound, (used_ff <= UW'(trwr_pkg::NODES)), "node count past table size")
   `TRWR_ASSERT(a_pair_space, (push.count == 2'd2) |-> (push.first.out_char == trwr_pkg::CHAR_SPACE), "two results without leading separator")
   `TRWR_ASSERT_NEVER(a_pop_clear, (pop && (phase_ff != trwr_pkg::PH_EXEC)), "request taken outside execute")
   `TRWR_ASSERT(a_exec_has_item, (phase_ff == trwr_pkg::PH_EXEC) |-> head_valid, "execute without queued request")

endmodule

// ----- hdl/trie_root_word_replacer_unit.sv -----
// ---------------------------------------------------------------------------
// trie_root_word_replacer_unit
// Shortest-root word replacement over a trie of dictionary words.
// ---------------------------------------------------------------------------
// Requests (req_) carry one byte: command 0 inserts a dictionary byte,
// command 1 filters a sentence byte; end_mark closes a word or sentence.
// Results (rsp_) carry the filtered bytes, single separator spaces, the
// sentence end flag and a status for dropped bytes. A request gives zero,
// one or two results.
// In the engine each request has a fetch state with one link memory read,
// then an execute state with the cursor update and any link write; the next
// request starts only after that execute state. Results are written into
// the result queue in the execute state and offered from there.
// Requests queue in a two-entry front queue and results in a four-entry
// result queue, so a stalled receiver only stops the engine once the
// result queue has fewer than two free places.
// After reset the link memory (NODES*ALPHABET = 26624 entries) is cleared
// one entry a cycle; req_ready stays low until the clear is done.
// ---------------------------------------------------------------------------
module trie_root_word_replacer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  trwr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output trwr_pkg::rsp_type rsp_payload
);

   logic               clear_done;
   logic               head_valid;
   trwr_pkg::item_type head;
   logic               pop;
   logic               space_ok;
   trwr_pkg::push_type push;

   trwr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .clear_done  (clear_done),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop)
   );

   trwr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_done (clear_done),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .space_ok   (space_ok),
      .push       (push)
   );

   trwr_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .space_ok    (space_ok),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
